// ----- rtl/core/hcc_pkg.sv -----
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared constants, codes and types for the Hamiltonian cycle checker.
// ----------------------------------------------------------------------------
package hcc_pkg;

  localparam int MAX_NODES  = 64;
  localparam int NODE_W     = 6;
  localparam int ROW_W      = 64;
  localparam int COUNT_W    = 7;
  localparam int TOTAL_W    = 11;
  localparam int LEN_W      = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(MAX_NODES);
  localparam logic [LEN_W-1:0]   LEN_MAX        = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CYCLE = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_NODE_COUNT = 1'b0
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FIRST  = 3'b010,
    S_SECOND = 3'b100
  } state_t;

endpackage

// ----- rtl/core/hcc_ram.sv -----
// ----------------------------------------------------------------------------
// hcc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module hcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/hamiltonian_cycle_checker.sv -----
// A request accepted in S_IDLE steps through S_FIRST and S_SECOND, and its result
// is loaded into the output register once no result is unread; no new request is
// taken before then, as both rows share the single adjacency row memory (read/modify/write).
// The output register lets a request be accepted while a result waits.
// Reset is synchronous; the row memory is not swept: per-row valid bits are
// cleared at once, so the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
// hamiltonian_cycle_checker
// Adjacency bitmap graph store with streamed Hamiltonian cycle verification.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_checker (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [hcc_pkg::IN_DATA_W-1:0]  s_tdata,   // node_a[5:0], node_b[11:6], zero pad
  input  logic                           s_tlast,   // last_node
  input  logic [1:0]                     s_tuser,   // operation[1:0]
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hcc_pkg::OUT_DATA_W-1:0] m_tdata,   // edge_found[0], edge_total[11:1],
                                                    // cycle_done[12], cycle_ok[13], zero pad
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hcc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hcc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  import hcc_pkg::*;

  // configuration
  logic [COUNT_W-1:0] node_count;
  logic [COUNT_W-1:0] n_eff;
  logic               cfg_sel;

  // control
  state_t            state;
  op_t               op_q;
  logic [NODE_W-1:0] a_q;
  logic [NODE_W-1:0] b_q;
  logic              last_q;
  logic              found_q;
  logic              add_go_q;

  // graph store
  logic [MAX_NODES-1:0] row_valid;
  logic [TOTAL_W-1:0]   edge_total;

  // sequence state
  logic [ROW_W-1:0]  visited;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] prev_node;
  logic [LEN_W-1:0]  seq_len;
  logic              seq_failed;

  // output register
  logic               out_found;
  logic [TOTAL_W-1:0] out_total;
  logic               out_done;
  logic               out_ok;

  // memory ports
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;

  // datapath
  logic              accept;
  logic              load;
  logic [NODE_W-1:0] addr1;
  logic [NODE_W-1:0] bit1_idx;
  logic [ROW_W-1:0]  row1;
  logic              pair1_ok;
  logic              found_now;
  logic              add_go_now;
  logic [ROW_W-1:0]  row2;
  logic [NODE_W-1:0] first_eff;
  logic              close_ok;
  logic              fail_next;
  logic [LEN_W-1:0]  len_next;
  logic              cycle_ok_now;

  hcc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = (reg_idx_t'(paddr[2]) == REG_NODE_COUNT);
  assign prdata  = cfg_sel ? CFG_DATA_W'(node_count) : '0;
  assign n_eff   = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      node_count <= pwdata[COUNT_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == S_SECOND) && (!m_tvalid || m_tready);

  // ---------------- first row: edge lookup ----------------
  assign addr1    = (op_q == OP_CYCLE) ? prev_node : a_q;
  assign bit1_idx = (op_q == OP_CYCLE) ? a_q : b_q;
  assign row1     = row_valid[addr1] ? rd_data : '0;
  assign pair1_ok = ({1'b0, addr1} < n_eff) && ({1'b0, bit1_idx} < n_eff);
  assign found_now  = pair1_ok && row1[bit1_idx];
  assign add_go_now = pair1_ok && (a_q != b_q) && !found_now;

  // ---------------- second row: closing edge / mirror update ----------------
  assign row2      = row_valid[bit1_idx] ? rd_data : '0;
  assign first_eff = (seq_len == '0) ? a_q : first_node;
  assign close_ok  = ({1'b0, a_q} < n_eff) && ({1'b0, first_eff} < n_eff)
                     && row2[first_eff];
  assign fail_next = seq_failed || ({1'b0, a_q} >= n_eff) || visited[a_q]
                     || ((seq_len != '0) && !found_q);
  assign len_next  = (seq_len < LEN_MAX) ? seq_len + LEN_W'(1) : seq_len;
  assign cycle_ok_now = !fail_next && (n_eff != '0) && (len_next == n_eff) && close_ok;

  // ---------------- memory access ----------------
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = a_q;
    wr_data = row1 | (ROW_W'(1) << b_q);
    case (state)
      S_IDLE: begin
        rd_en   = accept;
        rd_addr = (op_t'(s_tuser) == OP_CYCLE) ? prev_node : s_tdata[NODE_W-1:0];
      end
      S_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = bit1_idx;
        wr_en   = (op_q == OP_ADD) && add_go_now;
      end
      S_SECOND: begin
        wr_en   = load && (op_q == OP_ADD) && add_go_q;
        wr_addr = b_q;
        wr_data = row2 | (ROW_W'(1) << a_q);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // ---------------- control and state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_valid  <= '0;
      edge_total <= '0;
      visited    <= '0;
      first_node <= '0;
      prev_node  <= '0;
      seq_len    <= '0;
      seq_failed <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          state <= S_SECOND;
        end
        S_SECOND: begin
          if (load) begin
            state <= S_IDLE;
            case (op_q)
              OP_CLEAR: begin
                row_valid  <= '0;
                edge_total <= '0;
              end
              OP_ADD: begin
                if (add_go_q) begin
                  edge_total <= edge_total + TOTAL_W'(1);
                end
              end
              OP_CYCLE: begin
                if (last_q) begin
                  visited    <= '0;
                  first_node <= '0;
                  prev_node  <= '0;
                  seq_len    <= '0;
                  seq_failed <= 1'b0;
                end else begin
                  visited[a_q] <= 1'b1;
                  first_node   <= first_eff;
                  prev_node    <= a_q;
                  seq_len      <= len_next;
                  seq_failed   <= fail_next;
                end
              end
              default: ;
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(s_tuser);
      a_q    <= s_tdata[NODE_W-1:0];
      b_q    <= s_tdata[2*NODE_W-1:NODE_W];
      last_q <= s_tlast;
    end
    if (state == S_FIRST) begin
      found_q  <= found_now;
      add_go_q <= add_go_now;
    end
    if (load) begin
      out_found <= ((op_q == OP_ADD) || (op_q == OP_QUERY)) && found_q;
      out_done  <= (op_q == OP_CYCLE) && last_q;
      out_ok    <= (op_q == OP_CYCLE) && last_q && cycle_ok_now;
      case (op_q)
        OP_CLEAR: out_total <= '0;
        OP_ADD:   out_total <= add_go_q ? edge_total + TOTAL_W'(1) : edge_total;
        default:  out_total <= edge_total;
      endcase
    end
  end

  assign m_tdata = {2'b00, out_ok, out_done, out_total, out_found};

endmodule
